// File: rtl/mfr_pkg.sv
// Shared types and constants for the multipole frame rotation block.
`timescale 1ns / 1ps
package mfr_pkg;

    // Axis components are Q1.16; one spare bit covers rounding at full length.
    localparam int AXIS_W = 19;
    typedef logic signed [AXIS_W-1:0] t_axis;

    localparam t_axis AXIS_ONE     = 19'sd65536;
    localparam t_axis Z_ONLY_LIMIT = 19'sd56753;

    // Register stages from a normalizer input register to its output register.
    localparam int NORM_LAT = 30;

    // Split point of the exact chiral volume product.
    localparam int VOL_SPLIT = 22;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_Z_ONLY,
        KIND_Z_THEN_X,
        KIND_BISECTOR,
        KIND_Z_BISECTOR,
        KIND_THREE_FOLD
    } t_kind;

endpackage

// File: rtl/mfr_norm.sv
// Pipelined vector normalizer: squared length, digit-by-digit root, per-component divide.
`timescale 1ns / 1ps
module mfr_norm
    import mfr_pkg::*;
#(
    parameter int IW = 22
) (
    input  logic                 i_clk,
    input  logic                 i_ce,
    input  logic signed [IW-1:0] i_vec [3],
    output t_axis                o_axis [3]
);

    localparam int SW     = 2 * IW + 1;
    localparam int RADW   = 64;
    localparam int REMW   = 36;
    localparam int RTW    = 32;
    localparam int DVW    = 48;
    localparam int QW     = 17;
    localparam int SQ0    = 5;
    localparam int SQ_END = SQ0 + 15;
    localparam int DV0    = SQ_END + 1;
    localparam int DV_END = DV0 + 8;

    typedef struct packed {
        logic [2:0][IW-1:0] mag;
        logic [2:0]         neg;
        logic [4:0]         k;
        logic               zero;
    } t_nside;

    logic [2*IW-1:0] r_sq [3];
    logic [2*IW-1:0] n_sq [3];
    logic [SW-1:0]   r_sum;
    logic [SW-1:0]   n_sum;
    logic [SW-1:0]   r_sk;
    t_nside          r_ns [1:DV_END];
    t_nside          n_ns [1:DV_END];
    logic [RADW-1:0] r_rad [4:SQ_END];
    logic [RADW-1:0] n_rad [4:SQ_END];
    logic [REMW-1:0] r_rem [4:SQ_END];
    logic [REMW-1:0] n_rem [4:SQ_END];
    logic [RTW-1:0]  r_root [4:SQ_END];
    logic [RTW-1:0]  n_root [4:SQ_END];
    logic [RTW-1:0]  r_m [DV0:DV_END];
    logic [RTW-1:0]  n_m [DV0:DV_END];
    logic [DVW-1:0]  r_drem [DV0:DV_END][3];
    logic [DVW-1:0]  n_drem [DV0:DV_END][3];
    logic [QW-1:0]   r_q [DV0:DV_END][3];
    logic [QW-1:0]   n_q [DV0:DV_END][3];
    t_axis           r_out [3];
    t_axis           n_out [3];

    always_comb begin
        logic signed [2*IW-1:0] prod;
        logic [5:0]             p;
        logic [REMW-1:0]        rem;
        logic [REMW-1:0]        trial;
        logic [RTW-1:0]         rt;
        logic [RADW-1:0]        rad;
        logic [DVW-1:0]         dr;
        logic [DVW-1:0]         ms;
        logic [QW-1:0]          q;
        logic [RTW-1:0]         m;
        int                     b;

        // squares, magnitudes and signs
        n_ns[1] = '0;
        for (int i = 0; i < 3; i++) begin
            prod = (2*IW)'(i_vec[i]) * (2*IW)'(i_vec[i]);
            n_sq[i] = prod;
            n_ns[1].mag[i] = i_vec[i][IW-1] ? IW'(-i_vec[i]) : IW'(i_vec[i]);
            n_ns[1].neg[i] = i_vec[i][IW-1];
        end
        for (int s = 2; s <= DV_END; s++) begin
            n_ns[s] = r_ns[s-1];
        end

        n_sum = SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
        n_ns[2].zero = (n_sum == '0);

        // shift count that lifts the squared length to at least 2^60
        p = '0;
        for (int i = 0; i < SW; i++) begin
            if (r_sum[i]) begin
                p = 6'(i);
            end
        end
        n_ns[3].k = 5'((7'd61 - 7'(p)) >> 1);

        n_rad[4]  = RADW'(r_sk) << {r_ns[3].k, 1'b0};
        n_rem[4]  = '0;
        n_root[4] = '0;

        // two root bits per stage
        for (int j = SQ0; j <= SQ_END; j++) begin
            rem = r_rem[j-1];
            rt  = r_root[j-1];
            rad = r_rad[j-1];
            for (int t = 0; t < 2; t++) begin
                rem   = {rem[REMW-3:0], rad[RADW-1:RADW-2]};
                rad   = rad << 2;
                trial = (REMW'(rt) << 2) | REMW'(1);
                if (rem >= trial) begin
                    rem = rem - trial;
                    rt  = {rt[RTW-2:0], 1'b1};
                end else begin
                    rt  = {rt[RTW-2:0], 1'b0};
                end
            end
            n_rem[j]  = rem;
            n_root[j] = rt;
            n_rad[j]  = rad;
        end

        // two quotient bits per stage
        for (int j = DV0; j <= DV_END; j++) begin
            m = (j == DV0) ? r_root[SQ_END] : r_m[j-1];
            n_m[j] = m;
            for (int c = 0; c < 3; c++) begin
                if (j == DV0) begin
                    dr = DVW'(r_ns[SQ_END].mag[c]) << (6'(r_ns[SQ_END].k) + 6'd16);
                    q  = '0;
                end else begin
                    dr = r_drem[j-1][c];
                    q  = r_q[j-1][c];
                end
                for (int t = 0; t < 2; t++) begin
                    b = QW - 1 - 2 * (j - DV0) - t;
                    if (b >= 0) begin
                        ms = DVW'(m) << b;
                        if (dr >= ms) begin
                            dr = dr - ms;
                            q  = q | (QW'(1) << b);
                        end
                    end
                end
                n_drem[j][c] = dr;
                n_q[j][c]    = q;
            end
        end

        for (int i = 0; i < 3; i++) begin
            if (r_ns[DV_END].zero) begin
                n_out[i] = '0;
            end else if (r_ns[DV_END].neg[i]) begin
                n_out[i] = -t_axis'({1'b0, r_q[DV_END][i]});
            end else begin
                n_out[i] = t_axis'({1'b0, r_q[DV_END][i]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_sq  <= n_sq;
            r_sum <= n_sum;
            r_sk  <= r_sum;
            r_ns  <= n_ns;
            r_rad <= n_rad;
            r_rem <= n_rem;
            r_root <= n_root;
            r_m   <= n_m;
            r_drem <= n_drem;
            r_q   <= n_q;
            r_out <= n_out;
        end
    end

    assign o_axis = r_out;

endmodule

// File: rtl/multipole_frame_rotation_top.sv
// Top level: chiral check, frame build and multipole rotation pipeline.
`timescale 1ns / 1ps
// Multipole frame rotation, one atomic site per item.
// Slave channel (i_s_*): one site per item; tuser carries the frame kind,
// tlast marks the last site of a batch. Master channel (o_m_*): one rotated
// multipole per site, in input order, tlast copied from the input.
// Throughput: one item per cycle while the receiver does not stall. Each
// item passes three normalizers in series (30 stages each: squared
// length, 16 stages of two root bits, 9 stages of two quotient bits) plus
// frame setup, orthogonalization and the two-step quadrupole rotation.
// The chiral volume is computed exactly in a five-stage side path and
// applied to the local components of z-then-x frames before rotation.
// The pipeline advances as a whole whenever the output register is empty
// or taken; when the receiver stalls with a result waiting, every stage
// holds and o_s_tready drops. Bubbles in flight keep their slots.
// Reset clears only the valid bits; data registers are not reset.
module multipole_frame_rotation_top
    import mfr_pkg::*;
#(
    parameter int COORD_BITS = 21,
    parameter int COMP_BITS  = 20
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // chiral_sign, site_position, z_neighbor_position, x_neighbor_position,
    // y_neighbor_position, charge_in, dipole_in, quad_diag_in, quad_offdiag_in
    input  logic [((2 + 12 * COORD_BITS + 20 + 9 * COMP_BITS + 7) / 8) * 8 - 1:0] i_s_tdata,
    // frame_kind
    input  logic [2:0] i_s_tuser,
    input  logic i_s_tlast,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // charge_out, dipole_out, quad_diag_out, quad_offdiag_out, chiral_sign_out
    output logic [((22 + 9 * COMP_BITS + 7) / 8) * 8 - 1:0] o_m_tdata,
    output logic o_m_tlast
);

    localparam int CB    = COORD_BITS;
    localparam int DW    = CB + 1;
    localparam int NIW   = (DW > 20) ? DW : 20;
    localparam int MW    = COMP_BITS + 1;
    localparam int IN_W  = 2 + 12 * CB + 20 + 9 * COMP_BITS;
    localparam int OUT_W = 22 + 9 * COMP_BITS;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;
    localparam int O_ST  = 2;
    localparam int O_ZN  = O_ST + 3 * CB;
    localparam int O_XN  = O_ZN + 3 * CB;
    localparam int O_YN  = O_XN + 3 * CB;
    localparam int O_CH  = O_YN + 3 * CB;
    localparam int O_DP  = O_CH + 20;
    localparam int O_QD  = O_DP + 3 * COMP_BITS;
    localparam int O_QO  = O_QD + 3 * COMP_BITS;

    localparam int PW   = 2 * DW;
    localparam int CHW  = PW + 1 - VOL_SPLIT;
    localparam int HPW  = DW + CHW;
    localparam int LPW  = DW + VOL_SPLIT + 1;
    localparam int HSW  = HPW + 2;
    localparam int LSW  = LPW + 2;
    localparam int TTW  = HSW + VOL_SPLIT + 1;
    localparam int DOTW = 2 * AXIS_W + 2;
    localparam int DZW  = DOTW + AXIS_W;
    localparam int DPW  = MW + AXIS_W;
    localparam int BW   = DPW + 2;
    localparam int QPW  = AXIS_W + BW;

    localparam int S_FLIP = 7;
    localparam int S_A    = 1 + NORM_LAT;
    localparam int S_A1   = S_A + 1;
    localparam int S_B    = S_A1 + NORM_LAT;
    localparam int S_B1   = S_B + 1;
    localparam int S_B5   = S_B + 5;
    localparam int S_C    = S_B5 + NORM_LAT;
    localparam int S_C2   = S_C + 2;
    localparam int TOT    = S_C + 6;

    localparam int PJ [6] = '{0, 1, 2, 0, 0, 1};
    localparam int PI [6] = '{0, 1, 2, 1, 2, 2};

    typedef struct packed {
        logic [2:0]            kind;
        logic [1:0]            cs;
        logic                  last;
        logic [19:0]           charge;
        logic [2:0][MW-1:0]    d;
        logic [2:0][MW-1:0]    qd;
        logic [2:0][MW-1:0]    qo;
    } t_side;

    function automatic logic signed [63:0] rshr(input logic signed [63:0] x, input int n);
        return (x + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic logic [COMP_BITS-1:0] sat_c(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (COMP_BITS - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (x > hi) begin
            return COMP_BITS'(hi);
        end else if (x < lo) begin
            return COMP_BITS'(lo);
        end
        return COMP_BITS'(x);
    endfunction

    logic             w_ce;
    logic [TOT:1]     r_vld;
    t_side            r_side [1:TOT];
    t_side            n_side [1:TOT];

    logic signed [DW-1:0]  r1_tz [3], r1_tx [3], r1_ty [3];
    logic signed [DW-1:0]  r1_ad [3], r1_bd [3], r1_cd [3];
    logic signed [DW-1:0]  n1_tz [3], n1_tx [3], n1_ty [3];
    logic signed [DW-1:0]  n1_ad [3], n1_bd [3], n1_cd [3];
    logic signed [NIW-1:0] w_n1z [3], w_n1x [3], w_n1y [3];

    logic signed [PW-1:0]  r2_pp [6];
    logic signed [PW-1:0]  n2_pp [6];
    logic signed [DW-1:0]  r2_d [3], r3_d [3];
    logic signed [CHW-1:0] r3_ch [3];
    logic signed [CHW-1:0] n3_ch [3];
    logic [VOL_SPLIT-1:0]  r3_cl [3];
    logic [VOL_SPLIT-1:0]  n3_cl [3];
    logic signed [HPW-1:0] r4_hp [3];
    logic signed [LPW-1:0] r4_lp [3];
    logic signed [HSW-1:0] r5_hi;
    logic signed [LSW-1:0] r5_lo;
    logic                  r6_pos;
    logic                  r6_neg;
    logic signed [TTW-1:0] w_tot;

    t_axis                 w_za1 [3], w_xa1 [3], w_ya1 [3];
    t_axis                 r_dz [S_A1:S_B][3], r_dx [S_A1:S_B][3];
    t_axis                 n_fz [3], n_fx [3];
    logic signed [NIW-1:0] r_n2in [3];
    logic signed [NIW-1:0] n_n2in [3];
    t_axis                 w_n2 [3];

    t_axis                 r_b1_z [3], r_b1_x [3], n_b1_z [3], n_b1_x [3];
    logic signed [2*AXIS_W-1:0] r_b2_p [3];
    t_axis                 r_b2_z [3], r_b2_x [3];
    logic signed [DOTW-1:0] r_b3_dot;
    t_axis                 r_b3_z [3], r_b3_x [3];
    logic signed [DZW-1:0] r_b4_dz [3];
    t_axis                 r_b4_z [3], r_b4_x [3];
    logic signed [NIW-1:0] r_b5_t [3];
    logic signed [NIW-1:0] n_b5_t [3];
    t_axis                 r_cz [S_B5:S_C][3];
    t_axis                 w_xf [3];

    logic signed [2*AXIS_W-1:0] r_c1_p [6];
    t_axis                 r_c1_z [3], r_c1_x [3];
    t_axis                 r_a2 [3][3], n_a2 [3][3];
    t_axis                 r_a3 [3][3], r_a4 [3][3];
    logic signed [DPW-1:0] r_c3_dp [3][3];
    logic signed [DPW-1:0] r_c3_bp [3][3][3];
    logic signed [MW-1:0]  w_mp [3][3];
    logic [COMP_BITS-1:0]  r_c4_dip [3], n_c4_dip [3];
    logic signed [BW-1:0]  r_c4_b [3][3];
    logic [COMP_BITS-1:0]  r_c5_dip [3];
    logic signed [QPW-1:0] r_c5_qp [6][3];
    logic [COMP_BITS-1:0]  r_o_dip [3];
    logic [COMP_BITS-1:0]  r_o_q [6], n_o_q [6];

    assign w_ce       = !r_vld[TOT] || i_m_tready;
    assign o_s_tready = w_ce;

    // unpack and take the difference vectors
    always_comb begin
        logic signed [CB-1:0] st, zn, xn, yn;
        logic [1:0]           cs;
        for (int i = 0; i < 3; i++) begin
            st = $signed(i_s_tdata[O_ST + i * CB +: CB]);
            zn = $signed(i_s_tdata[O_ZN + i * CB +: CB]);
            xn = $signed(i_s_tdata[O_XN + i * CB +: CB]);
            yn = $signed(i_s_tdata[O_YN + i * CB +: CB]);
            n1_tz[i] = DW'(zn) - DW'(st);
            n1_tx[i] = DW'(xn) - DW'(st);
            n1_ty[i] = DW'(yn) - DW'(st);
            n1_ad[i] = DW'(st) - DW'(yn);
            n1_bd[i] = DW'(zn) - DW'(yn);
            n1_cd[i] = DW'(xn) - DW'(yn);
        end
        cs = i_s_tdata[1:0];
        n_side[1].kind   = i_s_tuser;
        n_side[1].cs     = (cs == 2'b10) ? 2'b11 : cs;
        n_side[1].last   = i_s_tlast;
        n_side[1].charge = i_s_tdata[O_CH +: 20];
        for (int i = 0; i < 3; i++) begin
            n_side[1].d[i]  = MW'($signed(i_s_tdata[O_DP + i * COMP_BITS +: COMP_BITS]));
            n_side[1].qd[i] = MW'($signed(i_s_tdata[O_QD + i * COMP_BITS +: COMP_BITS]));
            n_side[1].qo[i] = MW'($signed(i_s_tdata[O_QO + i * COMP_BITS +: COMP_BITS]));
        end
        for (int s = 2; s <= TOT; s++) begin
            n_side[s] = r_side[s-1];
        end
        // flip chirality on a volume sign mismatch
        if (r_side[S_FLIP-1].kind == KIND_Z_THEN_X && r_side[S_FLIP-1].cs != 2'b00 &&
            ((r_side[S_FLIP-1].cs[1] && r6_pos) || (!r_side[S_FLIP-1].cs[1] && r6_neg))) begin
            n_side[S_FLIP].cs    = 2'(-$signed(r_side[S_FLIP-1].cs));
            n_side[S_FLIP].d[1]  = MW'(-$signed(r_side[S_FLIP-1].d[1]));
            n_side[S_FLIP].qo[0] = MW'(-$signed(r_side[S_FLIP-1].qo[0]));
            n_side[S_FLIP].qo[2] = MW'(-$signed(r_side[S_FLIP-1].qo[2]));
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_n1z[i] = NIW'(r1_tz[i]);
            w_n1x[i] = NIW'(r1_tx[i]);
            w_n1y[i] = NIW'(r1_ty[i]);
        end
    end

    // exact chiral volume
    always_comb begin
        logic signed [PW:0] c;
        n2_pp[0] = PW'(r1_bd[1]) * PW'(r1_cd[2]);
        n2_pp[1] = PW'(r1_bd[2]) * PW'(r1_cd[1]);
        n2_pp[2] = PW'(r1_cd[1]) * PW'(r1_ad[2]);
        n2_pp[3] = PW'(r1_cd[2]) * PW'(r1_ad[1]);
        n2_pp[4] = PW'(r1_ad[1]) * PW'(r1_bd[2]);
        n2_pp[5] = PW'(r1_ad[2]) * PW'(r1_bd[1]);
        for (int i = 0; i < 3; i++) begin
            c = (PW + 1)'(r2_pp[2*i]) - (PW + 1)'(r2_pp[2*i+1]);
            n3_ch[i] = CHW'(c >>> VOL_SPLIT);
            n3_cl[i] = c[VOL_SPLIT-1:0];
        end
        w_tot = (TTW'(r5_hi) <<< VOL_SPLIT) + TTW'(r5_lo);
    end

    // frame setup after the first normalizers
    always_comb begin
        logic far;
        far = (w_za1[0] > Z_ONLY_LIMIT) || (w_za1[0] < -Z_ONLY_LIMIT);
        for (int i = 0; i < 3; i++) begin
            n_fz[i]   = w_za1[i];
            n_fx[i]   = w_xa1[i];
            n_n2in[i] = '0;
        end
        unique case (r_side[S_A].kind)
            KIND_Z_ONLY: begin
                n_fx[0] = far ? t_axis'(0) : AXIS_ONE;
                n_fx[1] = far ? AXIS_ONE : t_axis'(0);
                n_fx[2] = '0;
            end
            KIND_BISECTOR: begin
                for (int i = 0; i < 3; i++) begin
                    n_n2in[i] = NIW'(w_za1[i]) + NIW'(w_xa1[i]);
                end
            end
            KIND_Z_BISECTOR: begin
                for (int i = 0; i < 3; i++) begin
                    n_n2in[i] = NIW'(w_xa1[i]) + NIW'(w_ya1[i]);
                end
            end
            KIND_THREE_FOLD: begin
                for (int i = 0; i < 3; i++) begin
                    n_n2in[i] = NIW'(w_za1[i]) + NIW'(w_xa1[i]) + NIW'(w_ya1[i]);
                end
            end
            default: begin
            end
        endcase

        for (int i = 0; i < 3; i++) begin
            n_b1_z[i] = r_dz[S_B][i];
            n_b1_x[i] = r_dx[S_B][i];
        end
        unique case (r_side[S_B].kind)
            KIND_BISECTOR, KIND_THREE_FOLD: begin
                n_b1_z = w_n2;
            end
            KIND_Z_BISECTOR: begin
                n_b1_x = w_n2;
            end
            default: begin
            end
        endcase

        // remove the z component from x
        for (int i = 0; i < 3; i++) begin
            n_b5_t[i] = NIW'(64'(r_b4_x[i]) - rshr(64'(r_b4_dz[i]), 32));
        end
    end

    // final axes, then rotation
    always_comb begin
        t_axis                 ya [3];
        logic signed [63:0]    acc;
        logic [2:0]            kind;
        kind = r_side[S_C2 - 1].kind;
        for (int i = 0; i < 3; i++) begin
            ya[i] = t_axis'(rshr(64'(r_c1_p[2*i]) - 64'(r_c1_p[2*i+1]), 16));
        end
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                n_a2[j][i] = (i == j) ? AXIS_ONE : t_axis'(0);
            end
        end
        if (kind >= KIND_Z_ONLY && kind <= KIND_THREE_FOLD) begin
            n_a2[0] = r_c1_x;
            n_a2[1] = ya;
            n_a2[2] = r_c1_z;
        end

        w_mp[0][0] = $signed(r_side[S_C2].qd[0]);
        w_mp[1][1] = $signed(r_side[S_C2].qd[1]);
        w_mp[2][2] = $signed(r_side[S_C2].qd[2]);
        w_mp[0][1] = $signed(r_side[S_C2].qo[0]);
        w_mp[1][0] = $signed(r_side[S_C2].qo[0]);
        w_mp[0][2] = $signed(r_side[S_C2].qo[1]);
        w_mp[2][0] = $signed(r_side[S_C2].qo[1]);
        w_mp[1][2] = $signed(r_side[S_C2].qo[2]);
        w_mp[2][1] = $signed(r_side[S_C2].qo[2]);

        for (int i = 0; i < 3; i++) begin
            acc = 64'(r_c3_dp[0][i]) + 64'(r_c3_dp[1][i]) + 64'(r_c3_dp[2][i]);
            n_c4_dip[i] = sat_c(rshr(acc, 16));
        end
        for (int p = 0; p < 6; p++) begin
            acc = 64'(r_c5_qp[p][0]) + 64'(r_c5_qp[p][1]) + 64'(r_c5_qp[p][2]);
            n_o_q[p] = sat_c(rshr(acc, 32));
        end
    end

    mfr_norm #(.IW(NIW)) u_norm_z (
        .i_clk (i_clk), .i_ce (w_ce), .i_vec (w_n1z), .o_axis (w_za1)
    );
    mfr_norm #(.IW(NIW)) u_norm_x (
        .i_clk (i_clk), .i_ce (w_ce), .i_vec (w_n1x), .o_axis (w_xa1)
    );
    mfr_norm #(.IW(NIW)) u_norm_y (
        .i_clk (i_clk), .i_ce (w_ce), .i_vec (w_n1y), .o_axis (w_ya1)
    );
    mfr_norm #(.IW(NIW)) u_norm_mix (
        .i_clk (i_clk), .i_ce (w_ce), .i_vec (r_n2in), .o_axis (w_n2)
    );
    mfr_norm #(.IW(NIW)) u_norm_orth (
        .i_clk (i_clk), .i_ce (w_ce), .i_vec (r_b5_t), .o_axis (w_xf)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[TOT-1:1], i_s_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_side <= n_side;
            r1_tz <= n1_tz;
            r1_tx <= n1_tx;
            r1_ty <= n1_ty;
            r1_ad <= n1_ad;
            r1_bd <= n1_bd;
            r1_cd <= n1_cd;
            r2_pp <= n2_pp;
            r2_d  <= '{r1_ad[0], r1_bd[0], r1_cd[0]};
            r3_ch <= n3_ch;
            r3_cl <= n3_cl;
            r3_d  <= r2_d;
            for (int i = 0; i < 3; i++) begin
                r4_hp[i] <= HPW'(r3_d[i]) * HPW'(r3_ch[i]);
                r4_lp[i] <= LPW'(r3_d[i]) * LPW'($signed({1'b0, r3_cl[i]}));
            end
            r5_hi  <= HSW'(r4_hp[0]) + HSW'(r4_hp[1]) + HSW'(r4_hp[2]);
            r5_lo  <= LSW'(r4_lp[0]) + LSW'(r4_lp[1]) + LSW'(r4_lp[2]);
            r6_pos <= (w_tot > 0);
            r6_neg <= (w_tot < 0);

            r_dz[S_A1] <= n_fz;
            r_dx[S_A1] <= n_fx;
            for (int s = S_A1 + 1; s <= S_B; s++) begin
                r_dz[s] <= r_dz[s-1];
                r_dx[s] <= r_dx[s-1];
            end
            r_n2in <= n_n2in;

            r_b1_z <= n_b1_z;
            r_b1_x <= n_b1_x;
            for (int i = 0; i < 3; i++) begin
                r_b2_p[i] <= (2*AXIS_W)'(r_b1_x[i]) * (2*AXIS_W)'(r_b1_z[i]);
                r_b4_dz[i] <= DZW'(r_b3_dot) * DZW'(r_b3_z[i]);
            end
            r_b2_z   <= r_b1_z;
            r_b2_x   <= r_b1_x;
            r_b3_dot <= DOTW'(r_b2_p[0]) + DOTW'(r_b2_p[1]) + DOTW'(r_b2_p[2]);
            r_b3_z   <= r_b2_z;
            r_b3_x   <= r_b2_x;
            r_b4_z   <= r_b3_z;
            r_b4_x   <= r_b3_x;
            r_b5_t   <= n_b5_t;
            r_cz[S_B5] <= r_b4_z;
            for (int s = S_B5 + 1; s <= S_C; s++) begin
                r_cz[s] <= r_cz[s-1];
            end

            r_c1_p[0] <= (2*AXIS_W)'(r_cz[S_C][1]) * (2*AXIS_W)'(w_xf[2]);
            r_c1_p[1] <= (2*AXIS_W)'(r_cz[S_C][2]) * (2*AXIS_W)'(w_xf[1]);
            r_c1_p[2] <= (2*AXIS_W)'(r_cz[S_C][2]) * (2*AXIS_W)'(w_xf[0]);
            r_c1_p[3] <= (2*AXIS_W)'(r_cz[S_C][0]) * (2*AXIS_W)'(w_xf[2]);
            r_c1_p[4] <= (2*AXIS_W)'(r_cz[S_C][0]) * (2*AXIS_W)'(w_xf[1]);
            r_c1_p[5] <= (2*AXIS_W)'(r_cz[S_C][1]) * (2*AXIS_W)'(w_xf[0]);
            r_c1_z <= r_cz[S_C];
            r_c1_x <= w_xf;

            r_a2 <= n_a2;
            r_a3 <= r_a2;
            r_a4 <= r_a3;
            for (int j = 0; j < 3; j++) begin
                for (int i = 0; i < 3; i++) begin
                    r_c3_dp[j][i] <= DPW'($signed(r_side[S_C2].d[j])) * DPW'(r_a2[j][i]);
                    for (int k = 0; k < 3; k++) begin
                        r_c3_bp[j][i][k] <= DPW'(w_mp[j][k]) * DPW'(r_a2[k][i]);
                    end
                    r_c4_b[j][i] <= BW'(r_c3_bp[j][i][0]) + BW'(r_c3_bp[j][i][1]) +
                                    BW'(r_c3_bp[j][i][2]);
                end
            end
            r_c4_dip <= n_c4_dip;
            r_c5_dip <= r_c4_dip;
            for (int p = 0; p < 6; p++) begin
                for (int m = 0; m < 3; m++) begin
                    r_c5_qp[p][m] <= QPW'(r_a4[m][PJ[p]]) * QPW'(r_c4_b[m][PI[p]]);
                end
            end
            r_o_dip <= r_c5_dip;
            r_o_q   <= n_o_q;
        end
    end

    assign o_m_tvalid = r_vld[TOT];
    assign o_m_tlast  = r_side[TOT].last;
    assign o_m_tdata  = OUT_TW'({r_side[TOT].cs,
                                 r_o_q[5], r_o_q[4], r_o_q[3],
                                 r_o_q[2], r_o_q[1], r_o_q[0],
                                 r_o_dip[2], r_o_dip[1], r_o_dip[0],
                                 r_side[TOT].charge});

endmodule
